/* design/peer_counter_replay_table_defines.svh */
// assertion macros for the peer table
`ifndef PEER_COUNTER_REPLAY_TABLE_DEFINES_SVH
`define PEER_COUNTER_REPLAY_TABLE_DEFINES_SVH
`define PCRT_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) cond) \
		else $error("assertion failed");
`define PCRT_ASSERT_NR(label, cond) \
	label: assert property (@(posedge clk) cond) else $error("assertion failed");
`endif

/* design/pcrt_pkg.sv */
// shared types and codes of the peer table
package pcrt_pkg;
	localparam logic [2:0] FR_FREE = 3'd0;
	localparam logic [2:0] FR_FRESH = 3'd1;
	localparam logic [2:0] FR_EXPIRED = 3'd2;
	localparam logic [2:0] FR_FAILED = 3'd3;
	localparam logic [2:0] FR_RESERVED = 3'd4;
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_KEYREQ = 3'd1;
	localparam logic [2:0] ST_BADADDR = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_REPLAY = 3'd4;
	localparam logic [2:0] ST_AUTHFAIL = 3'd5;
	localparam logic [2:0] ST_NONE = 3'd6;
	localparam logic [2:0] FN_SEND = 3'd0;
	localparam logic [2:0] FN_RECV = 3'd1;
	localparam logic [2:0] FN_INSTALL = 3'd2;
	localparam logic [2:0] FN_FAIL = 3'd3;
	localparam logic [2:0] FN_POLL = 3'd4;
	localparam logic [1:0] CFG_MAX_NONCE = 2'd0;
	localparam logic [1:0] CFG_MAX_MSG = 2'd1;
	localparam logic [1:0] CFG_ROUTER_HI = 2'd2;
	localparam logic [1:0] CFG_ROUTER_LO = 2'd3;
	typedef struct packed {
		logic [63:0] id_high;
		logic [63:0] id_low;
		logic [15:0] local_msg;
		logic [7:0] local_nonce;
		logic [15:0] remote_msg;
		logic [7:0] remote_nonce;
		logic [31:0] last_active;
		logic [2:0] fresh;
	} slot_t;
endpackage

/* design/peer_counter_replay_table.sv */
// peer table top level: a lookup item runs a slot scan through one shared compare unit that
// visits one slot per cycle; install runs up to two scans, and a send that adds a peer runs a
// lookup, then a free-slot scan, a least-active scan plus evict, or both, and then the fill; a
// zero send address or an unused func code goes straight to the result without a scan; the
// block is not ready while an item is at work or while its result waits in the output register,
// and configuration is taken only while idle
module peer_counter_replay_table #(
	parameter int SLOTS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// func, peer_high, peer_low, to_security_port, rx_msg_count, rx_nonce_count,
	// auth_ok, now_seconds
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status, slot, msg_count, nonce_count
	output logic [31:0]  m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	typedef enum logic [2:0] {IDLE, SCAN, EVICT, FREE, DONE} st_t;
	typedef enum logic [1:0] {K_PEER, K_MARK, K_LEAST} kind_t;
	st_t state_q;
	kind_t kind_q;
	pcrt_pkg::slot_t tab_q [SLOTS];
	logic [7:0] max_nonce_q;
	logic [15:0] max_msg_q;
	logic [CW-1:0] known_q;
	logic [IW-1:0] idx_q, best_q;
	logic hit_q;
	logic [2:0] func_q;
	logic [63:0] phi_q, plo_q;
	logic sec_q, auth_q;
	logic [15:0] rxm_q;
	logic [7:0] rxn_q;
	logic [31:0] now_q;
	logic [2:0] mark_q;
	logic out_v_q;
	logic [31:0] out_q;
	logic cmp;
	pcrt_pkg::slot_t cur;
	always_comb begin
		cur = tab_q[idx_q];
		unique case (kind_q)
			K_PEER: cmp = (cur.id_high == phi_q) && (cur.id_low == plo_q);
			K_MARK: cmp = cur.fresh == mark_q;
			default: cmp = tab_q[best_q].last_active > cur.last_active;
		endcase
	end
	assign s_tready = (state_q == IDLE) && !out_v_q;
	assign cfg_ready = (state_q == IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;
	function automatic pcrt_pkg::slot_t cleared();
		pcrt_pkg::slot_t c;
		c = '0;
		c.local_nonce = 8'd1;
		return c;
	endfunction
	always_ff @(posedge clk or negedge arst_n) begin
		logic [IW-1:0] t;
		pcrt_pkg::slot_t s;
		logic [31:0] o;
		if (!arst_n) begin
			state_q <= IDLE;
			kind_q <= K_PEER;
			out_v_q <= 1'b0;
			max_nonce_q <= 8'hff;
			max_msg_q <= 16'hffff;
			known_q <= CW'(2);
			for (int k = 0; k < SLOTS; k++) begin
				s = cleared();
				if (k == 0) s.fresh = pcrt_pkg::FR_FRESH;
				else if (k == 1) s.fresh = pcrt_pkg::FR_RESERVED;
				tab_q[k] <= s;
			end
			idx_q <= '0;
			best_q <= '0;
			hit_q <= 1'b0;
			mark_q <= '0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					pcrt_pkg::CFG_MAX_NONCE: max_nonce_q <= cfg_data[7:0];
					pcrt_pkg::CFG_MAX_MSG: max_msg_q <= cfg_data[15:0];
					pcrt_pkg::CFG_ROUTER_HI: tab_q[0].id_high <= cfg_data;
					default: tab_q[0].id_low <= cfg_data;
				endcase
			end
			unique case (state_q)
				IDLE: begin
					if (s_tvalid && s_tready) begin
						func_q <= s_tdata[2:0];
						sec_q <= s_tdata[131];
						rxm_q <= s_tdata[147:132];
						rxn_q <= s_tdata[155:148];
						auth_q <= s_tdata[156];
						now_q <= s_tdata[188:157];
						hit_q <= 1'b0;
						unique case (s_tdata[2:0])
							pcrt_pkg::FN_SEND, pcrt_pkg::FN_RECV: begin
								kind_q <= K_PEER; idx_q <= '0;
								phi_q <= s_tdata[66:3];
								plo_q <= s_tdata[130:67];
								state_q <= (s_tdata[2:0] == pcrt_pkg::FN_SEND
									&& s_tdata[130:3] == '0) ? DONE : SCAN;
							end
							pcrt_pkg::FN_INSTALL, pcrt_pkg::FN_FAIL: begin
								kind_q <= K_PEER; idx_q <= IW'(2);
								phi_q <= tab_q[1].id_high;
								plo_q <= tab_q[1].id_low;
								state_q <= SCAN;
							end
							pcrt_pkg::FN_POLL: begin
								kind_q <= K_MARK; mark_q <= pcrt_pkg::FR_EXPIRED;
								idx_q <= '0;
								phi_q <= s_tdata[66:3];
								plo_q <= s_tdata[130:67];
								state_q <= SCAN;
							end
							default: begin
								phi_q <= s_tdata[66:3];
								plo_q <= s_tdata[130:67];
								state_q <= DONE;
							end
						endcase
					end
				end
				SCAN: begin
					if (kind_q == K_LEAST) begin
						if (cmp) best_q <= idx_q;
						if (idx_q == IW'(SLOTS - 1)) state_q <= EVICT;
						else idx_q <= idx_q + 1'b1;
					end else if (cmp && !hit_q) begin
						hit_q <= 1'b1;
						best_q <= idx_q;
						state_q <= (mark_q == pcrt_pkg::FR_FREE && kind_q == K_MARK)
							? FREE : DONE;
					end else if (idx_q == IW'(SLOTS - 1)) begin
						if (func_q == pcrt_pkg::FN_SEND && kind_q == K_PEER) begin
							if (known_q >= CW'(SLOTS)) begin
								kind_q <= K_LEAST; best_q <= IW'(2); idx_q <= IW'(2);
							end else begin
								kind_q <= K_MARK; mark_q <= pcrt_pkg::FR_FREE; idx_q <= '0;
							end
						end else if (func_q == pcrt_pkg::FN_INSTALL && kind_q == K_PEER) begin
							kind_q <= K_MARK; mark_q <= pcrt_pkg::FR_FREE; idx_q <= '0;
						end else if (kind_q == K_MARK && mark_q == pcrt_pkg::FR_FREE
							&& func_q == pcrt_pkg::FN_SEND) begin
							kind_q <= K_LEAST; best_q <= IW'(2); idx_q <= IW'(2);
						end else begin
							state_q <= DONE;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				EVICT: begin
					tab_q[best_q] <= cleared();
					if (known_q > '0) known_q <= known_q - 1'b1;
					if (kind_q == K_LEAST && mark_q == pcrt_pkg::FR_FREE) begin
						hit_q <= 1'b1;
						state_q <= FREE;
					end else begin
						kind_q <= K_MARK; mark_q <= pcrt_pkg::FR_FREE;
						idx_q <= '0; state_q <= SCAN;
					end
				end
				FREE: begin
					if (func_q == pcrt_pkg::FN_SEND) begin
						s = cleared();
						s.id_high = phi_q;
						s.id_low = plo_q;
						s.fresh = pcrt_pkg::FR_EXPIRED;
						tab_q[best_q] <= s;
						if (known_q < CW'(SLOTS)) known_q <= known_q + 1'b1;
						out_q <= {26'd0, 3'(best_q), pcrt_pkg::ST_KEYREQ};
						out_v_q <= 1'b1;
						state_q <= IDLE;
					end else begin
						state_q <= DONE;
					end
				end
				default: begin
					t = best_q;
					s = tab_q[t];
					o = {29'd0, pcrt_pkg::ST_NONE};
					out_v_q <= 1'b1;
					state_q <= IDLE;
					unique case (func_q)
						pcrt_pkg::FN_SEND: begin
							if (phi_q == '0 && plo_q == '0)
								o = {29'd0, pcrt_pkg::ST_BADADDR};
							else if ((t == IW'(1) && !sec_q) || s.fresh == pcrt_pkg::FR_EXPIRED)
								o = {26'd0, 3'(t), pcrt_pkg::ST_KEYREQ};
							else if (s.local_nonce == max_nonce_q) begin
								tab_q[t].fresh <= pcrt_pkg::FR_EXPIRED;
								o = {26'd0, 3'(t), pcrt_pkg::ST_KEYREQ};
							end else begin
								if (s.local_msg == max_msg_q) begin
									s.local_nonce = s.local_nonce + 8'd1;
									s.local_msg = '0;
									s.fresh = pcrt_pkg::FR_FRESH;
								end
								o = {2'd0, s.local_nonce, s.local_msg, 3'(t), pcrt_pkg::ST_OK};
								s.local_msg = s.local_msg + 16'd1;
								s.last_active = now_q;
								tab_q[t] <= s;
							end
						end
						pcrt_pkg::FN_RECV: begin
							if (!hit_q) o = {29'd0, pcrt_pkg::ST_NOTFOUND};
							else if (s.fresh == pcrt_pkg::FR_EXPIRED)
								o = {26'd0, 3'(t), pcrt_pkg::ST_KEYREQ};
							else if ((rxm_q <= s.remote_msg && rxn_q <= s.remote_nonce)
								|| rxn_q < s.remote_nonce)
								o = {26'd0, 3'(t), pcrt_pkg::ST_REPLAY};
							else if (!auth_q)
								o = {26'd0, 3'(t), pcrt_pkg::ST_AUTHFAIL};
							else begin
								tab_q[t].remote_msg <= rxm_q;
								tab_q[t].remote_nonce <= rxn_q;
								tab_q[t].last_active <= now_q;
								o = {26'd0, 3'(t), pcrt_pkg::ST_OK};
							end
						end
						pcrt_pkg::FN_INSTALL: begin
							if (hit_q) begin
								s = tab_q[1];
								s.fresh = pcrt_pkg::FR_FRESH;
								if (t != IW'(1)) begin
									tab_q[t] <= s;
									tab_q[1].id_high <= '0;
									tab_q[1].id_low <= '0;
								end else begin
									s.id_high = '0;
									s.id_low = '0;
									tab_q[1] <= s;
								end
								o = {26'd0, 3'(t), pcrt_pkg::ST_OK};
							end
						end
						pcrt_pkg::FN_FAIL: begin
							if (hit_q) begin
								tab_q[t].fresh <= pcrt_pkg::FR_FAILED;
								o = {26'd0, 3'(t), pcrt_pkg::ST_OK};
							end else o = {29'd0, pcrt_pkg::ST_NOTFOUND};
						end
						pcrt_pkg::FN_POLL: begin
							if (hit_q) begin
								tab_q[1].id_high <= s.id_high;
								tab_q[1].id_low <= s.id_low;
								o = {26'd0, 3'(t), pcrt_pkg::ST_OK};
							end else begin
								for (int k = 2; k < SLOTS; k++)
									if (tab_q[k].fresh == pcrt_pkg::FR_FAILED)
										tab_q[k].fresh <= pcrt_pkg::FR_EXPIRED;
							end
						end
						default: ;
					endcase
					out_q <= o;
				end
			endcase
		end
	end
	logic unused;
	assign unused = ^s_tdata[191:189];
endmodule

/* design/pcrt_checker.sv */
// port-level checks of the peer table
`include "peer_counter_replay_table_defines.svh"
module pcrt_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [31:0] m_tdata
);
	`PCRT_ASSERT(busy_after_accept, s_tvalid && s_tready |=> !s_tready)
	`PCRT_ASSERT(no_accept_while_out, m_tvalid |-> !s_tready)
	`PCRT_ASSERT(status_range, m_tvalid |-> m_tdata[2:0] != 3'd7)
	`PCRT_ASSERT_NR(idle_in_reset, !arst_n |-> !m_tvalid)
endmodule
bind peer_counter_replay_table pcrt_checker u_chk (.*);

/* tb/testbench.sv */
// testbench for the peer counter and replay table: random and directed items, scoreboard
`timescale 1ns / 1ps

module testbench;
	localparam int SLOTS = 8;
	localparam int SETTLE = 3 * SLOTS + 12;
	localparam int IDLE_LIMIT = 5000;
	localparam int POOL = 7;

	typedef struct {
		logic [2:0]  func;
		logic [63:0] peer_high;
		logic [63:0] peer_low;
		logic        to_sec;
		logic [15:0] rx_msg;
		logic [7:0]  rx_nonce;
		logic        auth_ok;
		logic [31:0] now;
	} item_t;

	typedef struct {
		logic [2:0]  status;
		logic [2:0]  slot;
		logic [15:0] msg_count;
		logic [7:0]  nonce_count;
	} result_t;

	class peer_table_scoreboard;
		logic [7:0]  max_nonce;
		logic [15:0] max_msg;
		logic [63:0] id_hi[SLOTS];
		logic [63:0] id_lo[SLOTS];
		logic [15:0] loc_msg[SLOTS];
		logic [7:0]  loc_nonce[SLOTS];
		logic [15:0] rem_msg[SLOTS];
		logic [7:0]  rem_nonce[SLOTS];
		logic [31:0] last_seen[SLOTS];
		logic [2:0]  fresh[SLOTS];
		int          known;
		result_t     expected_results[$];
		int          errors;

		function new();
			max_nonce = 8'hff;
			max_msg = 16'hffff;
			for (int i = 0; i < SLOTS; i++)
				wipe(i);
			fresh[0] = pcrt_pkg::FR_FRESH;
			fresh[1] = pcrt_pkg::FR_RESERVED;
			known = 2;
			errors = 0;
		endfunction

		function void wipe(int i);
			id_hi[i] = '0;
			id_lo[i] = '0;
			loc_msg[i] = '0;
			loc_nonce[i] = 8'd1;
			rem_msg[i] = '0;
			rem_nonce[i] = '0;
			last_seen[i] = '0;
			fresh[i] = pcrt_pkg::FR_FREE;
		endfunction

		function int lookup(logic [63:0] hi, logic [63:0] lo, int from);
			for (int i = from; i < SLOTS; i++)
				if (id_hi[i] == hi && id_lo[i] == lo)
					return i;
			return SLOTS;
		endfunction

		function int first_marked(logic [2:0] mark);
			for (int i = 0; i < SLOTS; i++)
				if (fresh[i] == mark)
					return i;
			return SLOTS;
		endfunction

		function int evict_oldest();
			int best;
			best = 2;
			for (int i = 2; i < SLOTS; i++)
				if (last_seen[best] > last_seen[i])
					best = i;
			wipe(best);
			if (known > 0)
				known--;
			return best;
		endfunction

		function void write_reg(logic [1:0] index, logic [63:0] value);
			case (index)
				pcrt_pkg::CFG_MAX_NONCE: max_nonce = value[7:0];
				pcrt_pkg::CFG_MAX_MSG: max_msg = value[15:0];
				pcrt_pkg::CFG_ROUTER_HI: id_hi[0] = value;
				pcrt_pkg::CFG_ROUTER_LO: id_lo[0] = value;
			endcase
		endfunction

		function void note_item(item_t it);
			result_t r;
			int i;
			r = '{pcrt_pkg::ST_NONE, 3'd0, 16'd0, 8'd0};
			case (it.func)
				pcrt_pkg::FN_SEND: begin
					if (it.peer_high == 0 && it.peer_low == 0) begin
						r.status = pcrt_pkg::ST_BADADDR;
					end else begin
						i = lookup(it.peer_high, it.peer_low, 0);
						if (i >= SLOTS) begin
							if (known >= SLOTS)
								void'(evict_oldest());
							i = first_marked(pcrt_pkg::FR_FREE);
							if (i >= SLOTS)
								i = evict_oldest();
							id_hi[i] = it.peer_high;
							id_lo[i] = it.peer_low;
							if (known < SLOTS)
								known++;
							fresh[i] = pcrt_pkg::FR_EXPIRED;
							r.status = pcrt_pkg::ST_KEYREQ;
						end else if (i == 1 && !it.to_sec) begin
							r.status = pcrt_pkg::ST_KEYREQ;
						end else if (fresh[i] == pcrt_pkg::FR_EXPIRED) begin
							r.status = pcrt_pkg::ST_KEYREQ;
						end else if (loc_nonce[i] == max_nonce) begin
							fresh[i] = pcrt_pkg::FR_EXPIRED;
							r.status = pcrt_pkg::ST_KEYREQ;
						end else begin
							if (loc_msg[i] == max_msg) begin
								loc_nonce[i] = loc_nonce[i] + 8'd1;
								loc_msg[i] = '0;
								fresh[i] = pcrt_pkg::FR_FRESH;
							end
							r.msg_count = loc_msg[i];
							r.nonce_count = loc_nonce[i];
							loc_msg[i] = loc_msg[i] + 16'd1;
							last_seen[i] = it.now;
							r.status = pcrt_pkg::ST_OK;
						end
						r.slot = i[2:0];
					end
				end
				pcrt_pkg::FN_RECV: begin
					i = lookup(it.peer_high, it.peer_low, 0);
					if (i >= SLOTS) begin
						r.status = pcrt_pkg::ST_NOTFOUND;
					end else begin
						r.slot = i[2:0];
						if (fresh[i] == pcrt_pkg::FR_EXPIRED)
							r.status = pcrt_pkg::ST_KEYREQ;
						else if ((it.rx_msg <= rem_msg[i] && it.rx_nonce <= rem_nonce[i]) ||
								it.rx_nonce < rem_nonce[i])
							r.status = pcrt_pkg::ST_REPLAY;
						else if (!it.auth_ok)
							r.status = pcrt_pkg::ST_AUTHFAIL;
						else begin
							rem_msg[i] = it.rx_msg;
							rem_nonce[i] = it.rx_nonce;
							last_seen[i] = it.now;
							r.status = pcrt_pkg::ST_OK;
						end
					end
				end
				pcrt_pkg::FN_INSTALL: begin
					i = lookup(id_hi[1], id_lo[1], 2);
					if (i >= SLOTS)
						i = first_marked(pcrt_pkg::FR_FREE);
					if (i < SLOTS) begin
						id_hi[i] = id_hi[1];
						id_lo[i] = id_lo[1];
						loc_msg[i] = loc_msg[1];
						loc_nonce[i] = loc_nonce[1];
						rem_msg[i] = rem_msg[1];
						rem_nonce[i] = rem_nonce[1];
						last_seen[i] = last_seen[1];
						fresh[i] = pcrt_pkg::FR_FRESH;
						id_hi[1] = '0;
						id_lo[1] = '0;
						r.status = pcrt_pkg::ST_OK;
						r.slot = i[2:0];
					end
				end
				pcrt_pkg::FN_FAIL: begin
					i = lookup(id_hi[1], id_lo[1], 2);
					if (i < SLOTS) begin
						fresh[i] = pcrt_pkg::FR_FAILED;
						r.status = pcrt_pkg::ST_OK;
						r.slot = i[2:0];
					end else begin
						r.status = pcrt_pkg::ST_NOTFOUND;
					end
				end
				pcrt_pkg::FN_POLL: begin
					i = first_marked(pcrt_pkg::FR_EXPIRED);
					if (i < SLOTS) begin
						id_hi[1] = id_hi[i];
						id_lo[1] = id_lo[i];
						r.status = pcrt_pkg::ST_OK;
						r.slot = i[2:0];
					end else begin
						for (int k = 2; k < SLOTS; k++)
							if (fresh[k] == pcrt_pkg::FR_FAILED)
								fresh[k] = pcrt_pkg::FR_EXPIRED;
					end
				end
				default: ;
			endcase
			expected_results.push_back(r);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("%0t: %s got %0d want %0d", $realtime, what, got, want);
			errors++;
		endtask

		task check_result(logic [31:0] data);
			result_t w;
			if (expected_results.size() == 0) begin
				report("result with nothing pending, tdata", data, 0);
			end else begin
				w = expected_results.pop_front();
				if (data[2:0] !== w.status)
					report("status", data[2:0], w.status);
				if (data[5:3] !== w.slot)
					report("slot", data[5:3], w.slot);
				if (data[21:6] !== w.msg_count)
					report("msg_count", data[21:6], w.msg_count);
				if (data[29:22] !== w.nonce_count)
					report("nonce_count", data[29:22], w.nonce_count);
			end
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [31:0]  m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [63:0]  cfg_data;

	peer_counter_replay_table #(.SLOTS(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	peer_table_scoreboard sb = new();
	logic [63:0] pool_hi[POOL];
	logic [63:0] pool_lo[POOL];
	logic [31:0] clock_now;
	int          burst_left;
	int          ready_pct = 100;
	int          pct_cycles = 0;
	int          idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (pct_cycles == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pct <= 100;
				1: ready_pct <= 75;
				2: ready_pct <= 40;
				default: ready_pct <= 10;
			endcase
			pct_cycles <= $urandom_range(20, 300);
		end else begin
			pct_cycles <= pct_cycles - 1;
		end
		m_tready <= ($urandom_range(0, 99) < ready_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [191:0] pack_item(item_t it);
		return {3'd0, it.now, it.auth_ok, it.rx_nonce, it.rx_msg, it.to_sec,
			it.peer_low, it.peer_high, it.func};
	endfunction

	task automatic push_item(item_t it);
		s_tvalid <= 1'b1;
		s_tdata <= pack_item(it);
		do @(posedge clk); while (!s_tready);
		sb.note_item(it);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
				: $urandom_range(0, 20);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_regs(logic [7:0] nonce_max, logic [15:0] msg_max,
			logic [63:0] router_hi, logic [63:0] router_lo);
		logic [63:0] vals[4];
		vals = '{{56'd0, nonce_max}, {48'd0, msg_max}, router_hi, router_lo};
		for (int k = 0; k < 4; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= k[1:0];
			cfg_data <= vals[k];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(k[1:0], vals[k]);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic item_t blank_item(logic [2:0] func);
		item_t it;
		it.func = func;
		it.peer_high = '0;
		it.peer_low = '0;
		it.to_sec = 1'($urandom_range(0, 1));
		it.rx_msg = 16'($urandom);
		it.rx_nonce = 8'($urandom);
		it.auth_ok = 1'($urandom_range(0, 1));
		clock_now = clock_now + $urandom_range(0, 3);
		it.now = ($urandom_range(0, 30) == 0) ? $urandom : clock_now;
		return it;
	endfunction

	function automatic item_t aim(item_t it);
		int p;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			p = $urandom_range(0, POOL - 1);
			it.peer_high = pool_hi[p];
			it.peer_low = pool_lo[p];
		end else if (pick < 86) begin
			it.peer_high = sb.id_hi[0];
			it.peer_low = sb.id_lo[0];
		end else if (pick < 92) begin
			it.peer_high = sb.id_hi[1];
			it.peer_low = sb.id_lo[1];
		end else if (pick < 95) begin
			it.peer_high = '0;
			it.peer_low = '0;
		end else begin
			it.peer_high = {$urandom, $urandom};
			it.peer_low = {$urandom, $urandom};
		end
		return it;
	endfunction

	function automatic item_t shape_rx(item_t it);
		int i;
		i = sb.lookup(it.peer_high, it.peer_low, 0);
		if (i < SLOTS) begin
			case ($urandom_range(0, 3))
				0, 1: begin
					it.rx_nonce = sb.rem_nonce[i] + 8'($urandom_range(0, 1));
					it.rx_msg = sb.rem_msg[i] + 16'($urandom_range(1, 4));
					it.auth_ok = ($urandom_range(0, 5) != 0);
				end
				2: begin
					it.rx_nonce = sb.rem_nonce[i] - 8'($urandom_range(0, 1));
					it.rx_msg = sb.rem_msg[i] - 16'($urandom_range(0, 2));
				end
				default: ;
			endcase
		end
		return it;
	endfunction

	function automatic item_t random_item();
		item_t it;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			it = aim(blank_item(pcrt_pkg::FN_SEND));
		end else if (pick < 70) begin
			it = shape_rx(aim(blank_item(pcrt_pkg::FN_RECV)));
		end else if (pick < 80) begin
			it = blank_item(pcrt_pkg::FN_POLL);
		end else if (pick < 88) begin
			it = blank_item(pcrt_pkg::FN_INSTALL);
		end else if (pick < 93) begin
			it = blank_item(pcrt_pkg::FN_FAIL);
		end else if (pick < 96) begin
			it = blank_item(3'($urandom_range(5, 7)));
		end else begin
			it = blank_item(3'($urandom_range(0, 7)));
			it.peer_high = {$urandom, $urandom};
			it.peer_low = {$urandom, $urandom};
		end
		return it;
	endfunction

	task automatic random_phase(int count);
		int pause_at;
		pause_at = $urandom_range(count / 4, 3 * count / 4);
		for (int n = 0; n < count; n++) begin
			if (n == pause_at) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (sb.expected_results.size() != 0)
					@(posedge clk);
			end
			push_item(random_item());
		end
	endtask

	task automatic directed();
		item_t it;
		it = blank_item(pcrt_pkg::FN_SEND);
		push_item(it);
		it = blank_item(pcrt_pkg::FN_SEND);
		it.peer_high = '1;
		it.peer_low = '1;
		it.now = '1;
		push_item(it);
		it = blank_item(pcrt_pkg::FN_RECV);
		it.peer_high = '1;
		it.peer_low = '1;
		push_item(it);
		push_item(blank_item(pcrt_pkg::FN_FAIL));
		push_item(blank_item(pcrt_pkg::FN_POLL));
		it = blank_item(pcrt_pkg::FN_SEND);
		it.peer_high = '1;
		it.peer_low = '1;
		it.to_sec = 1'b0;
		push_item(it);
		it.to_sec = 1'b1;
		push_item(it);
		push_item(blank_item(pcrt_pkg::FN_INSTALL));
		push_item(blank_item(pcrt_pkg::FN_INSTALL));
		it = blank_item(pcrt_pkg::FN_SEND);
		it.peer_high = '1;
		it.peer_low = '1;
		it.now = '0;
		push_item(it);
		push_item(it);
		it = blank_item(pcrt_pkg::FN_RECV);
		it.peer_high = '1;
		it.peer_low = '1;
		it.rx_msg = '1;
		it.rx_nonce = '1;
		it.auth_ok = 1'b0;
		push_item(it);
		it.auth_ok = 1'b1;
		push_item(it);
		it.rx_msg = '0;
		it.rx_nonce = '0;
		push_item(it);
		it = blank_item(pcrt_pkg::FN_RECV);
		it.peer_high = 64'h1;
		push_item(it);
		push_item(blank_item(pcrt_pkg::FN_POLL));
		push_item(blank_item(pcrt_pkg::FN_FAIL));
		push_item(blank_item(pcrt_pkg::FN_POLL));
		push_item(blank_item(pcrt_pkg::FN_POLL));
		it = blank_item(pcrt_pkg::FN_SEND);
		it.peer_high = sb.id_hi[0];
		it.peer_low = sb.id_lo[0];
		push_item(it);
		for (int f = 5; f < 8; f++)
			push_item(blank_item(f[2:0]));
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= pcrt_pkg::CFG_MAX_NONCE;
		cfg_data <= '0;
		burst_left = 0;
		clock_now = $urandom;
		for (int p = 0; p < POOL; p++) begin
			pool_hi[p] = {$urandom, $urandom};
			pool_lo[p] = {$urandom, $urandom};
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		drain();
		write_regs(8'hff, 16'hffff, {$urandom, $urandom}, {$urandom, $urandom});
		random_phase(450);
		drain();
		write_regs(8'd4, 16'd2, '1, '1);
		random_phase(450);
		drain();
		write_regs(8'd0, 16'd0, '0, 64'd1);
		random_phase(400);
		drain();
		write_regs(8'($urandom_range(2, 254)), 16'($urandom_range(1, 6)), '0, '0);
		random_phase(450);
		drain();
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
